[src/srse_pkg.sv]
package srse_pkg;

  // field widths
  localparam int ROW_W   = 64;
  localparam int PIX_W   = 4;
  localparam int NPIX    = 16;
  localparam int X_W     = 10;
  localparam int COL_W   = 11;
  localparam int Y_W     = 8;
  localparam int ZOOM_W  = 4;
  localparam int PAL_W   = 8;
  localparam int PX_W    = 9;
  localparam int COLOR_W = 12;

  // row rejection limits
  localparam logic signed [X_W-1:0] LEFT_CUTOFF = -10'sd8;
  localparam logic [Y_W-1:0]        LAST_LINE   = 8'd223;

  // keep pattern per zoom value, bit i keeps source pixel i
  localparam logic [NPIX-1:0] KEEP_MASK [NPIX] = '{
    16'h0001, 16'h0101, 16'h0421, 16'h1111,
    16'h1249, 16'h2525, 16'h2A55, 16'h5555,
    16'h55AB, 16'h5B5B, 16'h6DB7, 16'h7777,
    16'h7BDF, 16'h7F7F, 16'h7FFF, 16'hFFFF
  };

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } srse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;
    logic step_done;
    logic flush_done;
    logic pend_valid;
  } srse_stat_t;

endpackage

[src/srse_if.sv]
interface srse_row_if;
  import srse_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        pixel_row;
  logic signed [X_W-1:0]   screen_x;
  logic [Y_W-1:0]          screen_y;
  logic [ZOOM_W-1:0]       zoom_x;
  logic                    flip_x;
  logic [PAL_W-1:0]        palette;

  modport source (output valid, pixel_row, screen_x, screen_y, zoom_x, flip_x, palette,
                  input ready);
  modport sink (input valid, pixel_row, screen_x, screen_y, zoom_x, flip_x, palette,
                output ready);
endinterface

interface srse_pixel_if;
  import srse_pkg::*;

  logic               valid;
  logic               ready;
  logic [PX_W-1:0]    pixel_x;
  logic [Y_W-1:0]     pixel_y;
  logic [COLOR_W-1:0] color_index;
  logic               last_pixel;

  modport source (output valid, pixel_x, pixel_y, color_index, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, color_index, last_pixel, output ready);
endinterface

[src/sprite_row_shrink_emitter.sv]
// channel     dir   fields
// row_in      in    pixel_row, screen_x, screen_y, zoom_x, flip_x, palette
// pixel_out   out   pixel_x, pixel_y, color_index, last_pixel
//
// a row is taken while idle, then scanned one source pixel per cycle (while
// the output does not stall) up to its highest kept position, then a flush
// hands over the final held pixel, if any, marked as the last pixel.
// a rejected row (too far left or below the screen) is dropped without a scan.
// a stalled output holds the scan; reset (rst, synchronous) empties all stages.
module sprite_row_shrink_emitter #(
  parameter int SCREEN_WIDTH = 320
) (
  input logic   clk,
  input logic   rst,
  srse_row_if.sink     row_in,
  srse_pixel_if.source pixel_out
);
  import srse_pkg::*;

  srse_cmd_t  cmd;
  srse_stat_t stat;

  srse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (row_in.valid),
    .in_ready (row_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srse_dp #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .pixel_row   (row_in.pixel_row),
    .screen_x    (row_in.screen_x),
    .screen_y    (row_in.screen_y),
    .zoom_x      (row_in.zoom_x),
    .flip_x      (row_in.flip_x),
    .palette     (row_in.palette),
    .out_valid   (pixel_out.valid),
    .out_ready   (pixel_out.ready),
    .pixel_x     (pixel_out.pixel_x),
    .pixel_y     (pixel_out.pixel_y),
    .color_index (pixel_out.color_index),
    .last_pixel  (pixel_out.last_pixel)
  );

`ifndef SYNTHESIS
  // a held-back pixel never coexists with a new row being taken
  a_pend_blocks_in: assert property (@(posedge clk) disable iff (rst)
    stat.pend_valid |-> !row_in.ready)
    else $error("pending pixel while row input ready");

  // emitted columns stay on the screen
  a_x_on_screen: assert property (@(posedge clk) disable iff (rst)
    pixel_out.valid |-> (int'(pixel_out.pixel_x) < SCREEN_WIDTH))
    else $error("pixel column off screen");

  // emitted lines stay on the screen
  a_y_on_screen: assert property (@(posedge clk) disable iff (rst)
    pixel_out.valid |-> (pixel_out.pixel_y <= LAST_LINE))
    else $error("pixel line off screen");

  // the last pixel leaves the scan with nothing held back
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (pixel_out.valid && pixel_out.last_pixel && !$past(pixel_out.valid)) |-> !stat.pend_valid)
    else $error("pixel still pending after last pixel");
`endif

endmodule

[src/srse_ctrl.sv]
module srse_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  srse_pkg::srse_stat_t stat,
  output srse_pkg::srse_cmd_t  cmd
);
  import srse_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FLUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        cmd.load = accept;
        if (accept && !stat.drop) begin
          state_next = SCAN;
        end
      end
      SCAN: begin
        cmd.step = 1'b1;
        if (stat.step_done) begin
          state_next = FLUSH;
        end
      end
      FLUSH: begin
        cmd.flush = 1'b1;
        if (stat.flush_done) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/srse_dp.sv]
module srse_dp #(
  parameter int SCREEN_WIDTH = 320
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  srse_pkg::srse_cmd_t                      cmd,
  output srse_pkg::srse_stat_t                     stat,
  input  logic [srse_pkg::ROW_W-1:0]               pixel_row,
  input  logic signed [srse_pkg::X_W-1:0]          screen_x,
  input  logic [srse_pkg::Y_W-1:0]                 screen_y,
  input  logic [srse_pkg::ZOOM_W-1:0]              zoom_x,
  input  logic                                     flip_x,
  input  logic [srse_pkg::PAL_W-1:0]               palette,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [srse_pkg::PX_W-1:0]                pixel_x,
  output logic [srse_pkg::Y_W-1:0]                 pixel_y,
  output logic [srse_pkg::COLOR_W-1:0]             color_index,
  output logic                                     last_pixel
);
  import srse_pkg::*;

  localparam logic signed [COL_W-1:0] X_LIMIT = COL_W'(SCREEN_WIDTH);

  // row being scanned
  logic [ROW_W-1:0]        row;
  logic [NPIX-1:0]         mask;
  logic signed [COL_W-1:0] col;
  logic [Y_W-1:0]          y_row;
  logic [PAL_W-1:0]        pal;

  // one pixel held back until the next one shows whether it is the last
  logic                    pend_valid;
  logic [PX_W-1:0]         pend_x;
  logic [COLOR_W-1:0]      pend_color;

  logic [ROW_W-1:0]        row_flip;
  logic                    hit;
  logic                    out_free;
  logic                    stall;
  logic                    advance;
  logic                    flush_go;

  // nibble reversal for flipped rows
  always_comb begin
    for (int i = 0; i < NPIX; i++) begin
      row_flip[i*PIX_W +: PIX_W] = pixel_row[(NPIX-1-i)*PIX_W +: PIX_W];
    end
  end

  // current source pixel test
  assign hit = mask[0] && (row[PIX_W-1:0] != '0) && (col >= 0) && (col < X_LIMIT);
  assign out_free = !out_valid || out_ready;
  assign stall    = hit && pend_valid && !out_free;
  assign advance  = cmd.step && !stall;
  assign flush_go = cmd.flush && pend_valid && out_free;

  assign stat.drop       = (screen_x <= LEFT_CUTOFF) || (screen_y > LAST_LINE);
  assign stat.step_done  = !stall && (mask[NPIX-1:1] == '0);
  assign stat.flush_done = !pend_valid || out_free;
  assign stat.pend_valid = pend_valid;

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row   <= flip_x ? row_flip : pixel_row;
      mask  <= KEEP_MASK[zoom_x];
      col   <= COL_W'(screen_x);
      y_row <= screen_y;
      pal   <= palette;
    end else if (advance) begin
      row  <= row >> PIX_W;
      mask <= mask >> 1;
      col  <= col + COL_W'(mask[0]);
    end
  end

  // pending and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (advance && hit) begin
        pend_valid <= 1'b1;
        pend_x     <= col[PX_W-1:0];
        pend_color <= {pal, row[PIX_W-1:0]};
      end else if (flush_go) begin
        pend_valid <= 1'b0;
      end
      // output register loads the held pixel, clears once taken
      if ((advance && hit && pend_valid) || flush_go) begin
        out_valid   <= 1'b1;
        pixel_x     <= pend_x;
        pixel_y     <= y_row;
        color_index <= pend_color;
        last_pixel  <= flush_go;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
